// File: design/hlik_pkg.sv
`default_nettype none
package hlik_pkg;

   localparam int CordicSteps = 16;
   localparam int NumLegs     = 6;

   // Pose as it travels from the front end to the back end.
   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [16:0] pos_z;     // already includes the nominal height
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic        [14:0] height;
   } pose_type;

   typedef logic [NumLegs*16-1:0] legs_type;

   function automatic logic [16:0] atan_q16(input logic [3:0] idx);
      logic [16:0] v;
      unique case (idx)
         4'd0:  v = 17'd51472;
         4'd1:  v = 17'd30385;
         4'd2:  v = 17'd16055;
         4'd3:  v = 17'd8150;
         4'd4:  v = 17'd4091;
         4'd5:  v = 17'd2047;
         4'd6:  v = 17'd1024;
         4'd7:  v = 17'd512;
         4'd8:  v = 17'd256;
         4'd9:  v = 17'd128;
         4'd10: v = 17'd64;
         4'd11: v = 17'd32;
         4'd12: v = 17'd16;
         4'd13: v = 17'd8;
         4'd14: v = 17'd4;
         default: v = 17'd2;
      endcase
      return v;
   endfunction

   // Base anchors, Q4.12, indexed [leg][axis].
   function automatic logic signed [15:0] base_anchor(input int k, input int j);
      logic signed [15:0] t [0:5][0:2];
      t = '{'{-16'sd414, 16'sd3277, 16'sd1024}, '{16'sd414, 16'sd3277, 16'sd1024},
            '{16'sd3043, -16'sd1282, 16'sd1024}, '{16'sd2630, -16'sd1995, 16'sd1024},
            '{-16'sd2634, -16'sd1991, 16'sd1024}, '{-16'sd3047, -16'sd1274, 16'sd1024}};
      return t[3'(k)][2'(j)];
   endfunction

   // Platform anchors, Q4.12, indexed [leg][axis].
   function automatic logic signed [15:0] plat_anchor(input int k, input int j);
      logic signed [15:0] t [0:5][0:2];
      t = '{'{-16'sd2630, 16'sd1995, -16'sd205}, '{16'sd2630, 16'sd1995, -16'sd205},
            '{16'sd3043, 16'sd1282, -16'sd205}, '{16'sd414, -16'sd3277, -16'sd205},
            '{-16'sd414, -16'sd3277, -16'sd205}, '{-16'sd3043, 16'sd1282, -16'sd205}};
      return t[3'(k)][2'(j)];
   endfunction

endpackage
`default_nettype wire

// File: design/hlik_front.sv
`default_nettype none
module hlik_front
   import hlik_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [14:0]  csr_wdata,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire logic [95:0]  in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output pose_type          out_pose
);

   logic [14:0] height_ff;
   logic        valid_ff;
   pose_type    pose_ff;
   pose_type    pose_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_pose  = pose_ff;

   always_comb begin
      pose_in.pos_x  = in_data[15:0];
      pose_in.pos_y  = in_data[31:16];
      pose_in.pos_z  = 17'($signed(in_data[47:32])) + 17'($signed({1'b0, height_ff}));
      pose_in.roll   = in_data[63:48];
      pose_in.pitch  = in_data[79:64];
      pose_in.yaw    = in_data[95:80];
      pose_in.height = height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 15'd8192;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_we) height_ff <= csr_wdata;
         if (in_ready) valid_ff <= in_valid;
      end
      if (in_valid && in_ready) pose_ff <= pose_in;
   end

endmodule
`default_nettype wire

// File: design/hlik_fifo.sv
`default_nettype none
module hlik_fifo
   import hlik_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire pose_type in_pose,
   output logic          out_valid,
   input  wire logic     out_ready,
   output pose_type      out_pose
);

   pose_type    mem_ff [0:3];
   logic [1:0]  wptr_ff, rptr_ff;
   logic [2:0]  count_ff;
   logic        push, pop;

   assign in_ready  = count_ff != 3'd4;
   assign out_valid = count_ff != 3'd0;
   assign out_pose  = mem_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 2'd1;
         if (pop)  rptr_ff <= rptr_ff + 2'd1;
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wptr_ff] <= in_pose;
   end

endmodule
`default_nettype wire

// File: design/hlik_back.sv
`default_nettype none
module hlik_back
   import hlik_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire pose_type in_pose,
   output logic          out_valid,
   input  wire logic     out_ready,
   output legs_type      out_legs
);

   // Stage map: 0 fold, 1..16 CORDIC, 17 round, 18 products, 19 matrix,
   // 20 anchor products, 21 differences, 22 squares, 23..39 root, 40 result.
   localparam int Depth     = 41;
   localparam int CEnd      = 17;
   localparam int RootStart = 23;
   localparam int RootSteps = 17;

   logic              adv;
   logic [Depth-1:0]  vld_ff;

   assign adv      = !vld_ff[Depth-1] || out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], in_valid};
   end

   // Translation travels alongside.
   logic signed [16:0] tr_ff [0:RootStart-1][0:2];
   logic        [14:0] h_ff  [0:Depth-2];

   always_ff @(posedge clock) begin
      if (adv) begin
         tr_ff[0][0] <= 17'(in_pose.pos_x);
         tr_ff[0][1] <= 17'(in_pose.pos_y);
         tr_ff[0][2] <= in_pose.pos_z;
         h_ff[0]     <= in_pose.height;
         for (int s = 1; s < RootStart; s++) tr_ff[s] <= tr_ff[s-1];
         for (int s = 1; s < Depth-1; s++) h_ff[s] <= h_ff[s-1];
      end
   end

   // Three CORDIC lanes: roll, pitch, yaw.
   logic signed [19:0] cx_ff [0:CEnd-1][0:2];
   logic signed [19:0] cy_ff [0:CEnd-1][0:2];
   logic signed [19:0] cz_ff [0:CEnd-1][0:2];
   logic               neg_ff[0:CEnd-1][0:2];
   logic signed [15:0] ang [0:2];
   logic signed [15:0] s_ff [0:2], c_ff [0:2];

   assign ang[0] = in_pose.roll;
   assign ang[1] = in_pose.pitch;
   assign ang[2] = in_pose.yaw;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            logic signed [16:0] a;
            logic               n;
            logic signed [19:0] sx, sy, q0, q1;
            a = 17'(ang[l]);
            n = 1'b0;
            if (a > 17'sd12868) begin
               a = a - 17'sd25736; n = 1'b1;
            end else if (a < -17'sd12868) begin
               a = a + 17'sd25736; n = 1'b1;
            end
            cx_ff[0][l]  <= 20'sd39797;
            cy_ff[0][l]  <= '0;
            cz_ff[0][l]  <= 20'(a) <<< 3;
            neg_ff[0][l] <= n;
            for (int i = 0; i < CordicSteps; i++) begin
               sx = cx_ff[i][l] >>> i;
               sy = cy_ff[i][l] >>> i;
               if (!cz_ff[i][l][19]) begin
                  cx_ff[i+1][l] <= cx_ff[i][l] - sy;
                  cy_ff[i+1][l] <= cy_ff[i][l] + sx;
                  cz_ff[i+1][l] <= cz_ff[i][l] - 20'(atan_q16(4'(i)));
               end else begin
                  cx_ff[i+1][l] <= cx_ff[i][l] + sy;
                  cy_ff[i+1][l] <= cy_ff[i][l] - sx;
                  cz_ff[i+1][l] <= cz_ff[i][l] + 20'(atan_q16(4'(i)));
               end
               neg_ff[i+1][l] <= neg_ff[i][l];
            end
            q0 = (cx_ff[CEnd-1][l] + 20'sd2) >>> 2;
            q1 = (cy_ff[CEnd-1][l] + 20'sd2) >>> 2;
            if (q0 > 20'sd16384) q0 = 20'sd16384;
            if (q0 < -20'sd16384) q0 = -20'sd16384;
            if (q1 > 20'sd16384) q1 = 20'sd16384;
            if (q1 < -20'sd16384) q1 = -20'sd16384;
            if (neg_ff[CEnd-1][l]) begin
               q0 = -q0; q1 = -q1;
            end
            c_ff[l] <= 16'(q0);
            s_ff[l] <= 16'(q1);
         end
      end
   end

   // Stage 18: pairwise products, Q.28. Stage 19: matrix entries.
   logic signed [31:0] cycp_ff, sycp_ff, cpsr_ff, cpcr_ff, sycr_ff, cysr_ff;
   logic signed [31:0] sysr_ff, cycr_ff, cysp_ff, sysp_ff;
   logic signed [15:0] sr2_ff, cr2_ff, sp2_ff;
   logic signed [16:0] rot_ff [0:2][0:2];

   always_ff @(posedge clock) begin
      if (adv) begin
         cycp_ff <= c_ff[2] * c_ff[1];
         sycp_ff <= s_ff[2] * c_ff[1];
         cpsr_ff <= c_ff[1] * s_ff[0];
         cpcr_ff <= c_ff[1] * c_ff[0];
         sycr_ff <= s_ff[2] * c_ff[0];
         cysr_ff <= c_ff[2] * s_ff[0];
         sysr_ff <= s_ff[2] * s_ff[0];
         cycr_ff <= c_ff[2] * c_ff[0];
         cysp_ff <= c_ff[2] * s_ff[1];
         sysp_ff <= s_ff[2] * s_ff[1];
         sr2_ff  <= s_ff[0];
         cr2_ff  <= c_ff[0];
         sp2_ff  <= s_ff[1];
      end
   end

   function automatic logic signed [16:0] rnd14(input logic signed [31:0] v);
      logic signed [31:0] t;
      t = (v + 32'sd8192) >>> 14;
      return 17'(t);
   endfunction

   function automatic logic signed [16:0] rnd28(input logic signed [47:0] v);
      logic signed [47:0] t;
      t = (v + (48'sd1 <<< 27)) >>> 28;
      return 17'(t);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_ff[0][0] <= rnd14(cycp_ff);
         rot_ff[0][1] <= rnd28(-(48'(sycr_ff) <<< 14) + 48'(cysp_ff) * 48'(sr2_ff));
         rot_ff[0][2] <= rnd28((48'(sysr_ff) <<< 14) + 48'(cysp_ff) * 48'(cr2_ff));
         rot_ff[1][0] <= rnd14(sycp_ff);
         rot_ff[1][1] <= rnd28((48'(cycr_ff) <<< 14) + 48'(sysp_ff) * 48'(sr2_ff));
         rot_ff[1][2] <= rnd28(-(48'(cysr_ff) <<< 14) + 48'(sysp_ff) * 48'(cr2_ff));
         rot_ff[2][0] <= -17'(sp2_ff);
         rot_ff[2][1] <= rnd14(cpsr_ff);
         rot_ff[2][2] <= rnd14(cpcr_ff);
      end
   end

   // Stage 20: rotated anchor, stage 21: difference, stage 22: sum of squares.
   logic signed [33:0] acc_ff [0:NumLegs-1][0:2];
   logic signed [20:0] d_ff   [0:NumLegs-1][0:2];
   logic        [42:0] sum_ff [0:NumLegs-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NumLegs; k++) begin
            for (int j = 0; j < 3; j++) begin
               logic signed [33:0] a0;
               a0 = 34'(rot_ff[j][0] * plat_anchor(k, 0))
                  + 34'(rot_ff[j][1] * plat_anchor(k, 1))
                  + 34'(rot_ff[j][2] * plat_anchor(k, 2));
               acc_ff[k][j] <= a0;
               d_ff[k][j]   <= 21'((acc_ff[k][j] + 34'sd8192) >>> 14)
                             + 21'(tr_ff[20][j]) - 21'(base_anchor(k, j));
            end
            sum_ff[k] <= 43'(d_ff[k][0] * d_ff[k][0]) + 43'(d_ff[k][1] * d_ff[k][1])
                       + 43'(d_ff[k][2] * d_ff[k][2]);
         end
      end
   end

   // Square root: restoring, two radicand bits and one result bit per step; the
   // stages take the 43-bit sum as 44 bits and give 22 result bits in 22 steps
   // folded into RootSteps-1 stages of up to two steps.
   logic [43:0] rem_ff [0:RootSteps-1][0:NumLegs-1];
   logic [22:0] root_ff[0:RootSteps-1][0:NumLegs-1];
   logic [43:0] rad_ff [0:RootSteps-1][0:NumLegs-1];
   logic signed [15:0] leg_ff [0:NumLegs-1];

   function automatic int steps_at(input int s);
      return (s < 6) ? 2 : 1;
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NumLegs; k++) begin
            rem_ff[0][k]  <= '0;
            root_ff[0][k] <= '0;
            rad_ff[0][k]  <= 44'(sum_ff[k]);
            for (int s = 0; s < RootSteps-1; s++) begin
               logic [43:0] rm, rd, tr;
               logic [22:0] rt;
               rm = rem_ff[s][k];
               rt = root_ff[s][k];
               rd = rad_ff[s][k];
               for (int u = 0; u < 2; u++) begin
                  if (u < steps_at(s)) begin
                     rm = {rm[41:0], rd[43:42]};
                     rd = {rd[41:0], 2'b00};
                     tr = {19'd0, rt, 2'b01};
                     if (rm >= tr) begin
                        rm = rm - tr;
                        rt = {rt[21:0], 1'b1};
                     end else begin
                        rt = {rt[21:0], 1'b0};
                     end
                  end
               end
               rem_ff[s+1][k]  <= rm;
               root_ff[s+1][k] <= rt;
               rad_ff[s+1][k]  <= rd;
            end
            begin
               logic signed [24:0] lg;
               lg = 25'(root_ff[RootSteps-1][k])
                  + 25'(rem_ff[RootSteps-1][k] > 44'(root_ff[RootSteps-1][k]))
                  - 25'(h_ff[Depth-2]);
               if (lg > 25'sd32767) lg = 25'sd32767;
               if (lg < -25'sd32768) lg = -25'sd32768;
               leg_ff[k] <= 16'(lg);
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NumLegs; k++) out_legs[k*16 +: 16] = leg_ff[k];
   end

endmodule
`default_nettype wire

// File: design/hexapod_leg_length_ik.sv
// Channel   | Direction | tdata fields (low bit first)
// req_      | in        | pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle (96 bits)
// rsp_      | out       | leg_0 .. leg_5 (96 bits)
// csr_      | in        | nominal_height (15 bits)
//
// One pose is taken per cycle while req_tready is high; rsp_tvalid for a pose rises
// once it has passed the front register, the queue and the back-end pipeline.
// The back-end depth is set mainly by the 16-step CORDIC and the 22-bit square root pipelines.
// A four-entry queue sits between the input register and the arithmetic pipeline.
// Reset is synchronous and active high; nominal_height returns to 2.0 m.
// A stall on rsp_ with a result pending holds the whole arithmetic pipeline; the queue then fills before req_ stalls.
`default_nettype none
module hexapod_leg_length_ik
   import hlik_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [14:0]  csr_wdata,          // nominal_height
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,          // pos_x, pos_y, pos_z, roll, pitch, yaw
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata           // leg_0 .. leg_5
);

   logic     f_valid, f_ready, b_valid, b_ready;
   pose_type f_pose, b_pose;

   // Front end: registers the pose and folds in the nominal height.
   hlik_front u_front (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .out_valid(f_valid), .out_ready(f_ready), .out_pose(f_pose)
   );

   // Queue that decouples the front end from the arithmetic pipeline.
   hlik_fifo u_fifo (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_pose(f_pose),
      .out_valid(b_valid), .out_ready(b_ready), .out_pose(b_pose)
   );

   // Back end: trigonometry, transform, lengths.
   hlik_back u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready), .in_pose(b_pose),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_legs(rsp_tdata)
   );

endmodule
`default_nettype wire

// File: design/hlik_checker.sv
`default_nettype none
module hlik_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_early: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result right after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tready && !rsp_tvalid |=> req_tready)
      else $error("input stalled with empty output");

endmodule

bind hexapod_leg_length_ik hlik_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire

// File: dv/tb_hexapod_leg_length_ik.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_hexapod_leg_length_ik;
   import hlik_pkg::*;

   // Pose and leg result as they travel on the buses, lowest field first.
   typedef struct {
      logic signed [15:0] pos_x, pos_y, pos_z, roll, pitch, yaw;
   } pose_item_type;

   typedef struct {
      logic signed [15:0] leg [0:5];
   } leg_set_type;

   localparam int LatencyCycles = 43;
   localparam int CycleLimit    = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [14:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;

   // Local copy of the height register, updated together with each write.
   logic [14:0]  height_shadow = 15'd8192;
   leg_set_type  expected_legs [$];
   int           fail_count = 0;
   int           cycle_count = 0;
   // While set, the receiver stops accepting results.
   bit           hold_request = 1'b0;
   // When set, the receiver never stalls.
   bit           rsp_no_stall = 1'b0;
   bit           req_no_gap = 1'b0;

   hexapod_leg_length_ik u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // pos_x, pos_y, pos_z, roll, pitch, yaw
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)      // leg_0 .. leg_5
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor arithmetic.
   // ---------------------------------------------------------------------

   // Arithmetic shift right that rounds toward minus infinity.
   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   // CORDIC sine and cosine of a Q3.13 angle, both returned in Q.14.
   // Angles past a quarter turn are folded by half a turn and negated.
   task automatic sin_cos_q14(input longint angle, output longint s, output longint c);
      longint x, y, z, nx;
      bit     flip;
      longint steps [0:15];
      steps = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
      flip = 1'b0;
      if (angle > 12868) begin
         angle -= 25736;
         flip = 1'b1;
      end else if (angle < -12868) begin
         angle += 25736;
         flip = 1'b1;
      end
      x = 39797;
      y = 0;
      z = angle * 8;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - shift_floor(y, i);
            y  = y + shift_floor(x, i);
            z  = z - steps[i];
         end else begin
            nx = x + shift_floor(y, i);
            y  = y - shift_floor(x, i);
            z  = z + steps[i];
         end
         x = nx;
      end
      x = clamp_unit(shift_floor(x + 2, 2));
      y = clamp_unit(shift_floor(y + 2, 2));
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = y;
      c = x;
   endtask

   // Integer square root rounded to nearest; a remainder above the root rounds up.
   function automatic longint root_rounded(longint v);
      longint unsigned r, b, rem;
      r = 0;
      rem = v;
      b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (rem > r) r++;
      return longint'(r);
   endfunction

   // Computes the six leg extensions of one pose under the current height.
   task automatic compute_leg_lengths(input pose_item_type p, output leg_set_type res);
      longint t [0:2];
      longint rot [0:2][0:2];
      longint sr, cr, sp, cp, sy, cy, h, acc, d, sum, leg;
      h = longint'(height_shadow);
      t[0] = longint'(p.pos_x);
      t[1] = longint'(p.pos_y);
      t[2] = longint'(p.pos_z) + h;
      sin_cos_q14(longint'(p.roll), sr, cr);
      sin_cos_q14(longint'(p.pitch), sp, cp);
      sin_cos_q14(longint'(p.yaw), sy, cy);
      rot[0][0] = shift_floor(cy * cp + 8192, 14);
      rot[0][1] = shift_floor(-sy * cr * 16384 + cy * sp * sr + (64'sd1 << 27), 28);
      rot[0][2] = shift_floor(sy * sr * 16384 + cy * sp * cr + (64'sd1 << 27), 28);
      rot[1][0] = shift_floor(sy * cp + 8192, 14);
      rot[1][1] = shift_floor(cy * cr * 16384 + sy * sp * sr + (64'sd1 << 27), 28);
      rot[1][2] = shift_floor(-cy * sr * 16384 + sy * sp * cr + (64'sd1 << 27), 28);
      rot[2][0] = -sp;
      rot[2][1] = shift_floor(cp * sr + 8192, 14);
      rot[2][2] = shift_floor(cp * cr + 8192, 14);
      for (int k = 0; k < 6; k++) begin
         sum = 0;
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int m = 0; m < 3; m++)
               acc += rot[j][m] * longint'(plat_anchor(k, m));
            d = shift_floor(acc + 8192, 14) + t[j] - longint'(base_anchor(k, j));
            sum += d * d;
         end
         leg = root_rounded(sum) - h;
         if (leg > 32767) leg = 32767;
         if (leg < -32768) leg = -32768;
         res.leg[k] = leg[15:0];
      end
   endtask

   // ---------------------------------------------------------------------
   // Driving.
   // ---------------------------------------------------------------------

   // Sends one pose: waits a random gap unless req_no_gap is set, then holds it until the transfer.
   task automatic send_pose(input pose_item_type p);
      leg_set_type exp_legs;
      int          gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      compute_leg_lengths(p, exp_legs);
      req_tvalid <= 1'b1;
      req_tdata  <= {p.yaw, p.pitch, p.roll, p.pos_z, p.pos_y, p.pos_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // The transfer took place at this edge, so the result is owed from now on.
      expected_legs = {expected_legs, exp_legs};
   endtask

   task automatic finish_sending;
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every owed result has arrived, then lets the pipeline drain.
   task automatic wait_drained;
      while (expected_legs.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 4) @(posedge clock);
   endtask

   // Writes the height register; only called while the block is idle.
   task automatic write_height(input logic [14:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      height_shadow = value;
      @(posedge clock);
   endtask

   function automatic pose_item_type make_pose(int x, int y, int z, int r, int p, int w);
      pose_item_type q;
      q.pos_x = 16'(x);
      q.pos_y = 16'(y);
      q.pos_z = 16'(z);
      q.roll  = 16'(r);
      q.pitch = 16'(p);
      q.yaw   = 16'(w);
      return q;
   endfunction

   // Angles mostly in the specified range, sometimes anywhere in 16 bits.
   function automatic int random_angle();
      if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom)));
      return $urandom_range(0, 51472) - 25736;
   endfunction

   function automatic pose_item_type random_pose();
      int sel;
      pose_item_type q;
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
         // Full range translations drive the leg saturation.
         q = make_pose(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                       int'($signed(16'($urandom))), random_angle(), random_angle(),
                       random_angle());
      end else begin
         // Realistic poses within a few decimeters of home.
         q = make_pose($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                       $urandom_range(0, 4096) - 2048, $urandom_range(0, 4000) - 2000,
                       $urandom_range(0, 4000) - 2000, random_angle());
      end
      return q;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking and receiver stalls.
   // ---------------------------------------------------------------------

   initial begin : rsp_side
      int wait_cycles;
      leg_set_type want;
      logic signed [15:0] got;
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else begin
            wait_cycles = rsp_no_stall ? 0 : $urandom_range(0, 5);
            repeat (wait_cycles) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
            // A transfer of one result happened at this edge.
            if (expected_legs.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_legs.pop_front();
               for (int k = 0; k < 6; k++) begin
                  got = rsp_tdata[16*k +: 16];
                  if (got !== want.leg[k]) begin
                     $error("leg_%0d expected %0d actual %0d", k, want.leg[k], got);
                     fail_count++;
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Extremes of every field, the quarter and half turn folds and saturation.
   task automatic test_directed_poses;
      int a [0:8];
      a = '{0, 12868, 12869, -12868, -12869, 25736, -25736, 32767, -32768};
      send_pose(make_pose(0, 0, 0, 0, 0, 0));
      send_pose(make_pose(32767, 32767, 32767, 0, 0, 0));
      send_pose(make_pose(-32768, -32768, -32768, 0, 0, 0));
      send_pose(make_pose(-32768, 32767, 0, 0, 0, 0));
      for (int i = 1; i < 9; i++) send_pose(make_pose(100, -100, 200, a[i], 0, 0));
      for (int i = 1; i < 9; i++) send_pose(make_pose(-300, 50, -60, 0, a[i], a[9 - i]));
      send_pose(make_pose(32767, -32768, 32767, -32768, 32767, -32768));
      send_pose(make_pose(-1, -1, -1, -1, -1, -1));
      finish_sending();
      wait_drained();
   endtask

   task automatic test_random_poses(input int count);
      for (int i = 0; i < count; i++) send_pose(random_pose());
      finish_sending();
   endtask

   // Extreme heights and one random height, each followed by random poses and two directed ones.
   task automatic test_height_settings;
      logic [14:0] h [0:3];
      h = '{15'd0, 15'd32767, 15'd1, 15'($urandom)};
      foreach (h[i]) begin
         write_height(h[i]);
         test_random_poses(40);
         send_pose(make_pose(0, 0, 32767, 0, 0, 0));
         send_pose(make_pose(0, 0, -32768, 25736, -25736, 0));
         finish_sending();
         wait_drained();
      end
   endtask

   // The receiver holds off while poses keep coming, so the queue and the
   // pipeline fill and req_tready drops; the stretch is timed here and applied in the
   // receiver's own loop through hold_request.
   task automatic test_backpressure;
      fork
         begin
            hold_request = 1'b1;
            repeat (120) @(posedge clock);
            hold_request = 1'b0;
         end
         begin
            req_no_gap = 1'b1;
            test_random_poses(80);
            req_no_gap = 1'b0;
         end
      join
      wait_drained();
   endtask

   // Full rate in both directions, with no stalls at all.
   task automatic test_full_rate;
      req_no_gap   = 1'b1;
      rsp_no_stall = 1'b1;
      test_random_poses(200);
      wait_drained();
      req_no_gap   = 1'b0;
      rsp_no_stall = 1'b0;
   endtask

   initial begin : main
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_poses();
      test_height_settings();
      test_backpressure();
      test_full_rate();
      write_height(15'd8192);
      test_random_poses(700);
      // The sender pauses until every result is back before moving on.
      wait_drained();
      write_height(15'($urandom_range(4096, 12288)));
      test_random_poses(680);
      wait_drained();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
